// ----- design/mcfp_pkg.sv -----
`default_nettype none

package mcfp_pkg;

	typedef enum logic [2:0] {
		CmdFullSet    = 3'd0,
		CmdTorqueOnly = 3'd1,
		CmdEnterMode  = 3'd2,
		CmdExitMode   = 3'd3,
		CmdZeroPos    = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		RegPositionMin = 3'd0,
		RegPositionMax = 3'd1,
		RegVelocityMin = 3'd2,
		RegVelocityMax = 3'd3,
		RegTorqueMin   = 3'd4,
		RegTorqueMax   = 3'd5,
		RegKpGain      = 3'd6,
		RegKdGain      = 3'd7
	} reg_idx_t;

	localparam int CfgDataW = 17;

	// offsets that move each clamped value to a non-negative span
	localparam logic signed [16:0] PosOffset = 17'sd24448;
	localparam logic signed [16:0] VelOffset = 17'sd11520;
	localparam logic signed [16:0] TorOffset = 17'sd4608;

	// span of each scaled quantity; the code reaches its maximum exactly here
	localparam logic signed [16:0] PosSpan = 17'sd48896;
	localparam logic signed [16:0] VelSpan = 17'sd23040;
	localparam logic signed [16:0] TorSpan = 17'sd9216;
	localparam logic [16:0]        KpSpan  = 17'd128000;
	localparam logic [10:0]        KdSpan  = 11'd1280;

	// reset values of the clamp registers
	localparam logic signed [15:0] PosMinReset = -16'sd24448;
	localparam logic signed [15:0] PosMaxReset = 16'sd24448;
	localparam logic signed [14:0] VelMinReset = -15'sd11520;
	localparam logic signed [14:0] VelMaxReset = 15'sd11520;
	localparam logic signed [13:0] TorMinReset = -14'sd4608;
	localparam logic signed [13:0] TorMaxReset = 14'sd4608;

	// floor(s * Max / Span) == (s * Recip) >> Shift for 0 <= s <= Span,
	// with Recip = ceil(2^Shift * Max / Span) and Span^2 < 2^Shift
	localparam int PosShift = 32;
	localparam int VelShift = 32;
	localparam int TorShift = 32;
	localparam int KpShift  = 36;
	localparam int KdShift  = 32;

	localparam logic [63:0] PosRecip =
		((64'd1 << PosShift) * 64'd65535 + 64'd48895) / 64'd48896;
	localparam logic [63:0] VelRecip =
		((64'd1 << VelShift) * 64'd4095 + 64'd23039) / 64'd23040;
	localparam logic [63:0] TorRecip =
		((64'd1 << TorShift) * 64'd4095 + 64'd9215) / 64'd9216;
	localparam logic [63:0] KpRecip =
		((64'd1 << KpShift) * 64'd4095 + 64'd127999) / 64'd128000;
	localparam logic [63:0] KdRecip =
		((64'd1 << KdShift) * 64'd4095 + 64'd1279) / 64'd1280;

	localparam logic [63:0] FrameEnter = 64'hFFFF_FFFF_FFFF_FFFC;
	localparam logic [63:0] FrameExit  = 64'hFFFF_FFFF_FFFF_FFFD;
	localparam logic [63:0] FrameZero  = 64'hFFFF_FFFF_FFFF_FFFE;

endpackage

`default_nettype wire

// ----- design/motor_command_frame_packer_top.sv -----
`default_nettype none

// Motor command frame packer: turns each command into one 8-byte motor control
// frame (byte 0 in frame_data[63:56]). One command is accepted every cycle that
// in_ready is high; its frame is presented from the output register, behind the
// two register stages (clamp and offset, then constant-reciprocal scaling
// and packing). Backpressure on the frame side fills empty stages before in_ready
// drops. Configuration writes are always taken (cfg_ready is high) and apply
// to commands accepted after the write.
module motor_command_frame_packer_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [2:0]                        command,
	input  wire logic signed [15:0]                target_position,
	input  wire logic signed [15:0]                target_velocity,
	input  wire logic signed [15:0]                target_torque,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [63:0]                            frame_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [2:0]                        cfg_index,
	input  wire logic [mcfp_pkg::CfgDataW-1:0]     cfg_data
);

	logic signed [15:0] pos_min_q, pos_max_q;
	logic signed [14:0] vel_min_q, vel_max_q;
	logic signed [13:0] tor_min_q, tor_max_q;
	logic [16:0]        kp_gain_q;
	logic [10:0]        kd_gain_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_min_q <= mcfp_pkg::PosMinReset;
			pos_max_q <= mcfp_pkg::PosMaxReset;
			vel_min_q <= mcfp_pkg::VelMinReset;
			vel_max_q <= mcfp_pkg::VelMaxReset;
			tor_min_q <= mcfp_pkg::TorMinReset;
			tor_max_q <= mcfp_pkg::TorMaxReset;
			kp_gain_q <= '0;
			kd_gain_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (mcfp_pkg::reg_idx_t'(cfg_index))
				mcfp_pkg::RegPositionMin: pos_min_q <= cfg_data[15:0];
				mcfp_pkg::RegPositionMax: pos_max_q <= cfg_data[15:0];
				mcfp_pkg::RegVelocityMin: vel_min_q <= cfg_data[14:0];
				mcfp_pkg::RegVelocityMax: vel_max_q <= cfg_data[14:0];
				mcfp_pkg::RegTorqueMin:   tor_min_q <= cfg_data[13:0];
				mcfp_pkg::RegTorqueMax:   tor_max_q <= cfg_data[13:0];
				mcfp_pkg::RegKpGain:      kp_gain_q <= cfg_data[16:0];
				mcfp_pkg::RegKdGain:      kd_gain_q <= cfg_data[10:0];
				default: begin
				end
			endcase
		end
	end

	// pipeline control
	logic v_s1, out_valid_q;
	logic s1_en, out_en;

	assign out_en   = !out_valid_q || out_ready;
	assign s1_en    = !v_s1 || out_en;
	assign in_ready = s1_en;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_en) begin
				v_s1 <= in_valid;
			end
			if (out_en) begin
				out_valid_q <= v_s1;
			end
		end
	end

	// stage 1: clamp (max tested first), offset, limit to the scaling span
	logic signed [15:0] vel_hi, vel_lo, tor_hi, tor_lo;
	logic signed [15:0] pos_clamp, vel_clamp, tor_clamp;
	logic signed [16:0] pos_sum, vel_sum, tor_sum;
	logic [15:0]        pos_s;
	logic [14:0]        vel_s;
	logic [13:0]        tor_s;
	logic [16:0]        kp_s;
	logic [10:0]        kd_s;

	assign vel_hi = {vel_max_q[14], vel_max_q};
	assign vel_lo = {vel_min_q[14], vel_min_q};
	assign tor_hi = {{2{tor_max_q[13]}}, tor_max_q};
	assign tor_lo = {{2{tor_min_q[13]}}, tor_min_q};

	always_comb begin
		if (target_position > pos_max_q) begin
			pos_clamp = pos_max_q;
		end else if (target_position < pos_min_q) begin
			pos_clamp = pos_min_q;
		end else begin
			pos_clamp = target_position;
		end

		if (target_velocity > vel_hi) begin
			vel_clamp = vel_hi;
		end else if (target_velocity < vel_lo) begin
			vel_clamp = vel_lo;
		end else begin
			vel_clamp = target_velocity;
		end

		if (target_torque > tor_hi) begin
			tor_clamp = tor_hi;
		end else if (target_torque < tor_lo) begin
			tor_clamp = tor_lo;
		end else begin
			tor_clamp = target_torque;
		end
	end

	assign pos_sum = {pos_clamp[15], pos_clamp} + mcfp_pkg::PosOffset;
	assign vel_sum = {vel_clamp[15], vel_clamp} + mcfp_pkg::VelOffset;
	assign tor_sum = {tor_clamp[15], tor_clamp} + mcfp_pkg::TorOffset;

	// drop negative sums to zero; anything past the span saturates the code
	always_comb begin
		if (pos_sum[16]) begin
			pos_s = '0;
		end else if (pos_sum > mcfp_pkg::PosSpan) begin
			pos_s = mcfp_pkg::PosSpan[15:0];
		end else begin
			pos_s = pos_sum[15:0];
		end

		if (vel_sum[16]) begin
			vel_s = '0;
		end else if (vel_sum > mcfp_pkg::VelSpan) begin
			vel_s = mcfp_pkg::VelSpan[14:0];
		end else begin
			vel_s = vel_sum[14:0];
		end

		if (tor_sum[16]) begin
			tor_s = '0;
		end else if (tor_sum > mcfp_pkg::TorSpan) begin
			tor_s = mcfp_pkg::TorSpan[13:0];
		end else begin
			tor_s = tor_sum[13:0];
		end

		kp_s = (kp_gain_q > mcfp_pkg::KpSpan) ? mcfp_pkg::KpSpan : kp_gain_q;
		kd_s = (kd_gain_q > mcfp_pkg::KdSpan) ? mcfp_pkg::KdSpan : kd_gain_q;
	end

	mcfp_pkg::cmd_t cmd_s1;
	logic [15:0]    pos_s1;
	logic [14:0]    vel_s1;
	logic [13:0]    tor_s1;
	logic [16:0]    kp_s1;
	logic [10:0]    kd_s1;

	always_ff @(posedge clk) begin
		if (s1_en && in_valid) begin
			cmd_s1 <= mcfp_pkg::cmd_t'(command);
			pos_s1 <= pos_s;
			vel_s1 <= vel_s;
			tor_s1 <= tor_s;
			kp_s1  <= kp_s;
			kd_s1  <= kd_s;
		end
	end

	// stage 2: scale by constant reciprocal, pack
	logic [48:0] pos_prod;
	logic [44:0] vel_prod;
	logic [44:0] tor_prod;
	logic [48:0] kp_prod;
	logic [44:0] kd_prod;
	logic [15:0] pos_code;
	logic [11:0] vel_code, tor_code, kp_code, kd_code;
	logic [63:0] frame_next;
	logic [63:0] frame_q;

	assign pos_prod = 49'(pos_s1) * 49'(mcfp_pkg::PosRecip[32:0]);
	assign vel_prod = 45'(vel_s1) * 45'(mcfp_pkg::VelRecip[29:0]);
	assign tor_prod = 45'(tor_s1) * 45'(mcfp_pkg::TorRecip[30:0]);
	assign kp_prod  = 49'(kp_s1) * 49'(mcfp_pkg::KpRecip[31:0]);
	assign kd_prod  = 45'(kd_s1) * 45'(mcfp_pkg::KdRecip[33:0]);

	assign pos_code = pos_prod[mcfp_pkg::PosShift +: 16];
	assign vel_code = vel_prod[mcfp_pkg::VelShift +: 12];
	assign tor_code = tor_prod[mcfp_pkg::TorShift +: 12];
	assign kp_code  = kp_prod[mcfp_pkg::KpShift +: 12];
	assign kd_code  = kd_prod[mcfp_pkg::KdShift +: 12];

	always_comb begin
		case (cmd_s1)
			mcfp_pkg::CmdFullSet:    frame_next = {pos_code, vel_code, kp_code, kd_code,
				tor_code};
			mcfp_pkg::CmdTorqueOnly: frame_next = {52'd0, tor_code};
			mcfp_pkg::CmdEnterMode:  frame_next = mcfp_pkg::FrameEnter;
			mcfp_pkg::CmdExitMode:   frame_next = mcfp_pkg::FrameExit;
			mcfp_pkg::CmdZeroPos:    frame_next = mcfp_pkg::FrameZero;
			default:                 frame_next = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_en && v_s1) begin
			frame_q <= frame_next;
		end
	end

	assign frame_data = frame_q;

	// an empty output register never holds off a request
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("in_ready low with output register empty");

	// an accepted request always lands in stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted request lost before stage 1");

	// a held frame with stage 1 full must block new requests
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("request accepted into a full pipeline");

	// stage 1 drains into the output register when it is free
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && out_en |=> out_valid_q)
		else $error("stage 1 frame dropped");

endmodule

`default_nettype wire
